// ===== hdl/pwve_pkg.sv =====
// shared types and constants for the wavetable voice engine
package pwve_pkg;

    localparam int unsigned OPCODE_W = 3;
    localparam int unsigned NOTE_W   = 7;
    localparam int unsigned ADDR_W   = 12;
    localparam int unsigned DATA_W   = 16;
    localparam int unsigned MIX_W    = 27;
    localparam int unsigned PHASE_W  = 20;
    localparam int unsigned INC_W    = 16;
    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned ENV_W    = 8;
    localparam int unsigned LEN_W    = 13;
    localparam int unsigned ELEN_W   = 9;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W    = 13;
    localparam int unsigned PITCH_AW = 7;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'hFF;

    typedef enum logic [OPCODE_W-1:0] {
        OP_NOTE_ON    = 3'd0,
        OP_SAMPLE     = 3'd1,
        OP_ENVELOPE   = 3'd2,
        OP_LOAD_WAVE  = 3'd3,
        OP_LOAD_ENV   = 3'd4,
        OP_LOAD_PITCH = 3'd5,
        OP_NONE6      = 3'd6,
        OP_NONE7      = 3'd7
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAVE_LENGTH = 3'd0,
        REG_LOOP_LENGTH = 3'd1,
        REG_ATTACK      = 3'd2,
        REG_ENV_LENGTH  = 3'd3,
        REG_ALLOC_MODE  = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_ADDR,
        ST_SCAN_READ,
        ST_SCAN_STEP,
        ST_NOTE,
        ST_OUTPUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    capture;   // latch input word
        logic    clr_mix;   // reset accumulator and voice index
        logic    step;      // apply per-voice update for opcode
        logic    next_v;    // advance voice index
        logic    note;      // start the allocated voice
        logic    load;      // perform memory load
        logic    out_load;  // move result into output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        opcode_t op;
        logic    last_voice;
    } status_t;

endpackage

// ===== hdl/pwve_ram.sv =====
// generic single-port-write ram with registered read
module pwve_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/pwve_ctrl.sv =====
// sequencer for the voice engine
module pwve_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  pwve_pkg::status_t   status,
    output pwve_pkg::cmd_t      cmd
);
    pwve_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pwve_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    // output register frees when taken; a new word may be accepted while the
    // previous result still waits there
    assign in_ready = (state_reg == pwve_pkg::ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            pwve_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cmd.clr_mix = 1'b1;
                    state_next  = pwve_pkg::ST_SCAN_ADDR;
                end
            end
            pwve_pkg::ST_SCAN_ADDR:
            begin
                unique case (status.op)
                    pwve_pkg::OP_SAMPLE, pwve_pkg::OP_ENVELOPE, pwve_pkg::OP_NOTE_ON:
                    begin
                        state_next = pwve_pkg::ST_SCAN_READ;
                    end
                    default:
                    begin
                        cmd.load   = 1'b1;
                        state_next = pwve_pkg::ST_OUTPUT;
                    end
                endcase
            end
            pwve_pkg::ST_SCAN_READ:
            begin
                state_next = pwve_pkg::ST_SCAN_STEP;
            end
            pwve_pkg::ST_SCAN_STEP:
            begin
                cmd.step = 1'b1;
                if (status.last_voice)
                begin
                    state_next = (status.op == pwve_pkg::OP_NOTE_ON) ?
                                 pwve_pkg::ST_NOTE : pwve_pkg::ST_OUTPUT;
                end
                else
                begin
                    cmd.next_v = 1'b1;
                    state_next = pwve_pkg::ST_SCAN_READ;
                end
            end
            pwve_pkg::ST_NOTE:
            begin
                cmd.note   = 1'b1;
                state_next = pwve_pkg::ST_OUTPUT;
            end
            pwve_pkg::ST_OUTPUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = pwve_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pwve_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg)
        else $error("result dropped before taken");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output overwritten");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == pwve_pkg::ST_SCAN_ADDR)
        else $error("capture without scan start");
`endif
endmodule

// ===== hdl/pwve_datapath.sv =====
// voice state, memories and mixer
module pwve_datapath #(
    parameter int unsigned VOICES         = 8,
    parameter int unsigned WAVE_DEPTH     = 4096,
    parameter int unsigned ENVELOPE_DEPTH = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pwve_pkg::cmd_t                     cmd,
    output pwve_pkg::status_t                  status,
    input  logic [pwve_pkg::OPCODE_W-1:0]      opcode,
    input  logic [pwve_pkg::NOTE_W-1:0]        note_number,
    input  logic [pwve_pkg::ADDR_W-1:0]        load_address,
    input  logic [pwve_pkg::DATA_W-1:0]        load_data,
    input  logic                               cfg_we,
    input  logic [pwve_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pwve_pkg::CFG_W-1:0]         cfg_data,
    output logic signed [pwve_pkg::MIX_W-1:0]  mix_sample,
    output logic                               mix_valid
);
    localparam int unsigned VW  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int unsigned WAW = $clog2(WAVE_DEPTH);
    localparam int unsigned EAW = $clog2(ENVELOPE_DEPTH);
    localparam int unsigned PW  = pwve_pkg::PHASE_W;
    localparam logic [VW-1:0] LAST_V = VW'(VOICES - 1);

    logic [pwve_pkg::LEN_W-1:0]  wave_len_reg, loop_len_reg, attack_reg;
    logic [pwve_pkg::ELEN_W-1:0] env_len_reg;
    logic                        alloc_reg;

    pwve_pkg::opcode_t           op_reg;
    logic [pwve_pkg::NOTE_W-1:0] note_reg;
    logic [pwve_pkg::ADDR_W-1:0] addr_reg;
    logic [pwve_pkg::DATA_W-1:0] data_reg;

    logic [PW-1:0]                   phase_reg [VOICES];
    logic [pwve_pkg::INC_W-1:0]      inc_reg   [VOICES];
    logic [pwve_pkg::LEVEL_W-1:0]    level_reg [VOICES];
    logic [pwve_pkg::ENV_W-1:0]      eidx_reg  [VOICES];
    logic [VW-1:0]                   rr_reg;
    logic [VW-1:0]                   v_reg;
    logic [VW-1:0]                   best_reg;
    logic [pwve_pkg::LEVEL_W-1:0]    best_lvl_reg;
    logic signed [pwve_pkg::MIX_W-1:0] mix_reg;
    logic signed [pwve_pkg::MIX_W-1:0] mix_out_reg;
    logic                              valid_out_reg;

    // memories
    logic [pwve_pkg::DATA_W-1:0]  wave_rdata, pitch_rdata;
    logic [pwve_pkg::LEVEL_W-1:0] env_rdata;
    logic [PW-1:0]                cur_phase;
    logic [pwve_pkg::ENV_W-1:0]   cur_eidx;
    logic                         we_wave, we_env, we_pitch;

    assign cur_phase = phase_reg[v_reg];
    assign cur_eidx  = eidx_reg[v_reg];
    assign we_wave  = cmd.load && op_reg == pwve_pkg::OP_LOAD_WAVE;
    assign we_env   = cmd.load && op_reg == pwve_pkg::OP_LOAD_ENV;
    assign we_pitch = cmd.load && op_reg == pwve_pkg::OP_LOAD_PITCH;

    pwve_ram #(.WIDTH(pwve_pkg::DATA_W), .DEPTH(WAVE_DEPTH)) u_wave (
        .clk(clk), .we(we_wave), .waddr(WAW'(addr_reg)), .wdata(data_reg),
        .raddr(WAW'(cur_phase[PW-1:8])), .rdata(wave_rdata));
    pwve_ram #(.WIDTH(pwve_pkg::LEVEL_W), .DEPTH(ENVELOPE_DEPTH)) u_env (
        .clk(clk), .we(we_env), .waddr(EAW'(addr_reg)),
        .wdata(data_reg[pwve_pkg::LEVEL_W-1:0]),
        .raddr(cur_eidx[EAW-1:0]), .rdata(env_rdata));
    pwve_ram #(.WIDTH(pwve_pkg::DATA_W), .DEPTH(128)) u_pitch (
        .clk(clk), .we(we_pitch), .waddr(addr_reg[pwve_pkg::PITCH_AW-1:0]),
        .wdata(data_reg), .raddr(note_reg), .rdata(pitch_rdata));

    // per-voice arithmetic
    logic signed [pwve_pkg::LEVEL_W:0]   lvl_s;
    logic signed [pwve_pkg::MIX_W-1:0]   prod;
    logic [PW:0]                         sum_ph;
    logic [PW:0]                         wrap_lim;
    logic [PW-1:0]                       new_ph;
    logic                                env_go;

    assign lvl_s    = $signed({1'b0, level_reg[v_reg]});
    assign prod     = pwve_pkg::MIX_W'($signed(wave_rdata) * lvl_s);
    assign sum_ph   = {1'b0, cur_phase} + (PW+1)'(inc_reg[v_reg]);
    assign wrap_lim = (PW+1)'({wave_len_reg, 8'h00});
    assign new_ph   = (sum_ph >= wrap_lim) ?
                      PW'(sum_ph - (PW+1)'({loop_len_reg, 8'h00})) : PW'(sum_ph);
    assign env_go   = ({1'b0, cur_phase[PW-1:8]} >= pwve_pkg::LEN_W'(attack_reg)) &&
                      ({1'b0, cur_eidx} + 9'd1 < env_len_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_len_reg  <= 13'd4096;
            loop_len_reg  <= 13'd4096;
            attack_reg    <= '0;
            env_len_reg   <= 9'd256;
            alloc_reg     <= 1'b0;
            rr_reg        <= '0;
            valid_out_reg <= 1'b0;
            for (int i = 0; i < VOICES; i++)
            begin
                phase_reg[i] <= '0;
                inc_reg[i]   <= '0;
                level_reg[i] <= '0;
                eidx_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pwve_pkg::REG_WAVE_LENGTH: wave_len_reg <= cfg_data;
                    pwve_pkg::REG_LOOP_LENGTH: loop_len_reg <= cfg_data;
                    pwve_pkg::REG_ATTACK:      attack_reg   <= cfg_data;
                    pwve_pkg::REG_ENV_LENGTH:  env_len_reg  <= cfg_data[pwve_pkg::ELEN_W-1:0];
                    pwve_pkg::REG_ALLOC_MODE:  alloc_reg    <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd.step)
            begin
                if (op_reg == pwve_pkg::OP_SAMPLE && level_reg[v_reg] != '0)
                begin
                    phase_reg[v_reg] <= new_ph;
                end
                if (op_reg == pwve_pkg::OP_ENVELOPE && env_go)
                begin
                    level_reg[v_reg] <= env_rdata;
                    eidx_reg[v_reg]  <= cur_eidx + 8'd1;
                end
            end
            if (cmd.note)
            begin
                if (alloc_reg)
                begin
                    inc_reg[best_reg]   <= pitch_rdata;
                    phase_reg[best_reg] <= '0;
                    level_reg[best_reg] <= pwve_pkg::LEVEL_FULL;
                    eidx_reg[best_reg]  <= '0;
                end
                else
                begin
                    inc_reg[rr_reg]   <= pitch_rdata;
                    phase_reg[rr_reg] <= '0;
                    level_reg[rr_reg] <= pwve_pkg::LEVEL_FULL;
                    eidx_reg[rr_reg]  <= '0;
                    rr_reg <= (rr_reg == LAST_V) ? '0 : rr_reg + 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                valid_out_reg <= (op_reg == pwve_pkg::OP_SAMPLE);
            end
        end
    end

    // payload and scan registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= pwve_pkg::opcode_t'(opcode);
            note_reg <= note_number;
            addr_reg <= load_address;
            data_reg <= load_data;
        end
        if (cmd.clr_mix)
        begin
            mix_reg      <= '0;
            v_reg        <= '0;
            best_reg     <= '0;
            best_lvl_reg <= pwve_pkg::LEVEL_FULL;
        end
        else
        begin
            if (cmd.next_v)
            begin
                v_reg <= v_reg + 1'b1;
            end
            if (cmd.step)
            begin
                if (op_reg == pwve_pkg::OP_SAMPLE && level_reg[v_reg] != '0)
                begin
                    mix_reg <= mix_reg + prod;
                end
                if (level_reg[v_reg] < best_lvl_reg)
                begin
                    best_lvl_reg <= level_reg[v_reg];
                    best_reg     <= v_reg;
                end
            end
        end
        if (cmd.out_load)
        begin
            mix_out_reg <= (op_reg == pwve_pkg::OP_SAMPLE) ? mix_reg : '0;
        end
    end

    assign status.op         = op_reg;
    assign status.last_voice = (v_reg == LAST_V);
    assign mix_sample        = mix_out_reg;
    assign mix_valid         = valid_out_reg;
endmodule

// ===== hdl/polyphonic_wavetable_voice_engine.sv =====
// top level of the polyphonic wavetable voice engine
// sample, envelope and note-on words scan every voice (note on then starts a voice)
// before the result; load and unused opcodes skip the scan
// throughput: one word at a time, set by the voice scan through one shared
// multiply-accumulate and the registered memory read port
// reset: rst_n clears voices and config registers to defaults; memories are not cleared
module polyphonic_wavetable_voice_engine #(
    parameter int unsigned VOICES         = 8,
    parameter int unsigned WAVE_DEPTH     = 4096,
    parameter int unsigned ENVELOPE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [3:0]  s_axis_tuser,   // opcode[2:0], pad
    input  logic [39:0] s_axis_tdata,   // note_number[6:0], load_address[18:7], load_data[34:19]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // mix_sample[26:0]
    output logic        m_axis_tuser,   // mix_valid
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    pwve_pkg::cmd_t    cmd;
    pwve_pkg::status_t status;
    logic signed [pwve_pkg::MIX_W-1:0] mix_sample;

    pwve_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .status(status), .cmd(cmd));

    pwve_datapath #(.VOICES(VOICES), .WAVE_DEPTH(WAVE_DEPTH),
                    .ENVELOPE_DEPTH(ENVELOPE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .opcode(s_axis_tuser[2:0]),
        .note_number(s_axis_tdata[6:0]),
        .load_address(s_axis_tdata[18:7]),
        .load_data(s_axis_tdata[34:19]),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mix_sample(mix_sample), .mix_valid(m_axis_tuser));

    assign m_axis_tdata = {5'b0, mix_sample};
endmodule

// ===== bench/tb_polyphonic_wavetable_voice_engine.sv =====
// testbench for the polyphonic wavetable voice engine: directed table, random phases, scoreboard
module tb_polyphonic_wavetable_voice_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV = 8;
    localparam int WDEPTH = 4096;
    localparam int EDEPTH = 256;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        pwve_pkg::opcode_t op;
        logic [6:0]        note;
        logic [11:0]       addr;
        logic [15:0]       data;
    } word_t;

    typedef struct packed {
        logic [26:0] mix;
        logic        valid;
    } mix_t;

    typedef struct {
        word_t w;
        logic  has_exp;
        mix_t  exp;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [3:0]  s_axis_tuser;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [12:0] cfg_data;

    polyphonic_wavetable_voice_engine i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // engine model state
    logic [19:0] phase [NV];
    logic [15:0] incr [NV];
    logic [7:0]  level [NV];
    logic [7:0]  env_pos [NV];
    logic [2:0]  rr_voice;
    logic [15:0] wave_mem [WDEPTH];
    logic [7:0]  env_mem [EDEPTH];
    logic [15:0] pitch_mem [128];
    bit          wave_ok [WDEPTH];
    bit          env_ok [EDEPTH];
    bit          pitch_ok [128];
    logic [12:0] wave_len, loop_len, attack_len;
    logic [8:0]  env_len;
    logic        alloc_lowest;

    mix_t  expected_mix [$];
    int    errors;
    int    idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic mix_t mix_engine(word_t w);
        mix_t r;
        logic signed [63:0] acc;
        logic [31:0] p;
        int v;
        int lvl;
        r = '0;
        acc = 0;
        case (w.op)
            pwve_pkg::OP_NOTE_ON:
            begin
                if (alloc_lowest)
                begin
                    v = 0;
                    lvl = 255;
                    for (int i = 0; i < NV; i++)
                        if (level[i] < lvl)
                        begin
                            lvl = level[i];
                            v = i;
                        end
                end
                else
                begin
                    v = rr_voice;
                    rr_voice = (rr_voice == NV - 1) ? 3'd0 : rr_voice + 3'd1;
                end
                incr[v] = pitch_mem[w.note];
                phase[v] = '0;
                level[v] = 8'hFF;
                env_pos[v] = '0;
            end
            pwve_pkg::OP_SAMPLE:
            begin
                for (int i = 0; i < NV; i++)
                    if (level[i] != 0)
                    begin
                        acc += $signed({1'b0, level[i]}) *
                               $signed(wave_mem[phase[i][19:8] % WDEPTH]);
                        p = phase[i] + incr[i];
                        if (p >= ({19'd0, wave_len} << 8))
                            p = p - ({19'd0, loop_len} << 8);
                        phase[i] = p[19:0];
                    end
                r.mix = acc[26:0];
                r.valid = 1'b1;
            end
            pwve_pkg::OP_ENVELOPE:
                for (int i = 0; i < NV; i++)
                    if (phase[i][19:8] >= attack_len && env_pos[i] + 32'd1 < env_len)
                    begin
                        level[i] = env_mem[env_pos[i]];
                        env_pos[i] = env_pos[i] + 8'd1;
                    end
            pwve_pkg::OP_LOAD_WAVE:
            begin
                wave_mem[w.addr] = w.data;
                wave_ok[w.addr] = 1;
            end
            pwve_pkg::OP_LOAD_ENV:
            begin
                env_mem[w.addr[7:0]] = w.data[7:0];
                env_ok[w.addr[7:0]] = 1;
            end
            pwve_pkg::OP_LOAD_PITCH:
            begin
                pitch_mem[w.addr[6:0]] = w.data;
                pitch_ok[w.addr[6:0]] = 1;
            end
            default: ;
        endcase
        return r;
    endfunction

    // receiver: own stall pattern, compare against oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_mix.size() == 0)
            begin
                $display("%0t unexpected word: expected none, actual %h/%b",
                         $time, m_axis_tdata[26:0], m_axis_tuser);
                errors++;
            end
            else
            begin
                mix_t e;
                e = expected_mix.pop_front();
                if (m_axis_tdata[26:0] !== e.mix)
                begin
                    $display("%0t mix_sample mismatch: expected %h, actual %h",
                             $time, e.mix, m_axis_tdata[26:0]);
                    errors++;
                end
                if (m_axis_tuser !== e.valid)
                begin
                    $display("%0t mix_valid mismatch: expected %b, actual %b",
                             $time, e.valid, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    int stall_phase;
    always @(negedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if ((stall_phase / 200) % 3 == 0)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("polyphonic_wavetable_voice_engine verification failed");
            $finish;
        end
    end

    function automatic word_t mk(pwve_pkg::opcode_t op, int note, int addr, int data);
        word_t w;
        w.op = op;
        w.note = note[6:0];
        w.addr = addr[11:0];
        w.data = data[15:0];
        return w;
    endfunction

    task automatic send_raw(word_t w, logic has_exp, mix_t exp_r);
        mix_t r;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= {1'b0, w.op};
        s_axis_tdata <= {5'd0, w.data, w.addr, w.note};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = mix_engine(w);
        if (has_exp && r !== exp_r)
        begin
            $display("%0t table entry disagrees: expected %h, predicted %h",
                     $time, exp_r, r);
            errors++;
        end
        expected_mix.push_back(has_exp ? exp_r : r);
    endtask

    // loads any memory entry the word is about to read before the word itself
    task automatic send_word(word_t w, logic has_exp, mix_t exp_r);
        logic [11:0] idx;
        case (w.op)
            pwve_pkg::OP_NOTE_ON:
                if (!pitch_ok[w.note])
                    send_raw(mk(pwve_pkg::OP_LOAD_PITCH, 0, int'(w.note), $urandom),
                             1'b0, '0);
            pwve_pkg::OP_SAMPLE:
                for (int i = 0; i < NV; i++)
                begin
                    idx = phase[i][19:8];
                    if (level[i] != 0 && !wave_ok[idx])
                        send_raw(mk(pwve_pkg::OP_LOAD_WAVE, 0, int'(idx), $urandom),
                                 1'b0, '0);
                end
            pwve_pkg::OP_ENVELOPE:
                for (int i = 0; i < NV; i++)
                    if (phase[i][19:8] >= attack_len && env_pos[i] + 32'd1 < env_len &&
                        !env_ok[env_pos[i]])
                        send_raw(mk(pwve_pkg::OP_LOAD_ENV, 0, int'(env_pos[i]), $urandom),
                                 1'b0, '0);
            default: ;
        endcase
        send_raw(w, has_exp, exp_r);
    endtask

    task automatic gap();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        gap();
        while (expected_mix.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(pwve_pkg::cfg_index_t idx, logic [12:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            pwve_pkg::REG_WAVE_LENGTH: wave_len = val;
            pwve_pkg::REG_LOOP_LENGTH: loop_len = val;
            pwve_pkg::REG_ATTACK:      attack_len = val;
            pwve_pkg::REG_ENV_LENGTH:  env_len = val[8:0];
            pwve_pkg::REG_ALLOC_MODE:  alloc_lowest = val[0];
            default: ;
        endcase
    endtask

    // random word; wave loads lean toward the low addresses
    function automatic word_t rand_word(int loads_pct);
        word_t w;
        int k;
        int sel;
        w = mk(pwve_pkg::OP_NONE6, $urandom, $urandom, $urandom);
        sel = $urandom_range(0, 99);
        if (sel < loads_pct)
            w.op = pwve_pkg::opcode_t'($urandom_range(3, 5));
        else if (sel < loads_pct + 2)
            w.op = pwve_pkg::opcode_t'($urandom_range(6, 7));
        else
        begin
            k = $urandom_range(0, 9);
            w.op = (k < 2) ? pwve_pkg::OP_NOTE_ON :
                   (k < 8) ? pwve_pkg::OP_SAMPLE : pwve_pkg::OP_ENVELOPE;
        end
        if (w.op == pwve_pkg::OP_LOAD_WAVE && $urandom_range(0, 3) != 0)
            w.addr = 12'($urandom_range(0, 63));
        return w;
    endfunction

    row_t tbl [$];
    word_t w;
    int burst;

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = '0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        idle_cycles = 0;
        stall_phase = 0;
        for (int i = 0; i < NV; i++)
        begin
            phase[i] = '0;
            incr[i] = '0;
            level[i] = '0;
            env_pos[i] = '0;
        end
        rr_voice = '0;
        wave_len = 13'd4096;
        loop_len = 13'd4096;
        attack_len = '0;
        env_len = 9'd256;
        alloc_lowest = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(pwve_pkg::REG_WAVE_LENGTH, 13'd64);
        write_reg(pwve_pkg::REG_LOOP_LENGTH, 13'd48);

        // directed rows: extremes, every opcode, sample of idle engine
        tbl.push_back('{mk(pwve_pkg::OP_SAMPLE, 0, 0, 0), 1'b1, '{27'd0, 1'b1}});
        tbl.push_back('{mk(pwve_pkg::OP_NONE6, 127, 4095, 65535), 1'b1, '{27'd0, 1'b0}});
        tbl.push_back('{mk(pwve_pkg::OP_NONE7, 0, 0, 0), 1'b1, '{27'd0, 1'b0}});
        tbl.push_back('{mk(pwve_pkg::OP_LOAD_WAVE, 0, 0, 16'h8000), 1'b1, '{27'd0, 1'b0}});
        tbl.push_back('{mk(pwve_pkg::OP_LOAD_WAVE, 127, 1, 16'h7FFF), 1'b1, '{27'd0, 1'b0}});
        tbl.push_back('{mk(pwve_pkg::OP_LOAD_PITCH, 0, 4095, 16'hFFFF), 1'b1,
                        '{27'd0, 1'b0}});
        tbl.push_back('{mk(pwve_pkg::OP_LOAD_PITCH, 0, 0, 16'h0000), 1'b1, '{27'd0, 1'b0}});
        tbl.push_back('{mk(pwve_pkg::OP_LOAD_ENV, 0, 4095, 16'hFF00), 1'b1, '{27'd0, 1'b0}});
        // full level times most negative sample, all voices at phase 0
        for (int i = 0; i < NV; i++)
            tbl.push_back('{mk(pwve_pkg::OP_NOTE_ON, 0, 0, 0), 1'b1, '{27'd0, 1'b0}});
        tbl.push_back('{mk(pwve_pkg::OP_SAMPLE, 0, 0, 0), 1'b1,
                        '{27'(-8 * 255 * 32768), 1'b1}});
        tbl.push_back('{mk(pwve_pkg::OP_NOTE_ON, 127, 0, 0), 1'b0, '0});
        tbl.push_back('{mk(pwve_pkg::OP_SAMPLE, 0, 0, 0), 1'b0, '0});
        tbl.push_back('{mk(pwve_pkg::OP_ENVELOPE, 0, 0, 0), 1'b0, '0});
        tbl.push_back('{mk(pwve_pkg::OP_SAMPLE, 0, 0, 0), 1'b0, '0});
        foreach (tbl[i])
            send_word(tbl[i].w, tbl[i].has_exp, tbl[i].exp);
        drain();

        // random phases across register settings, extremes included
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin
                    write_reg(pwve_pkg::REG_ATTACK, 13'd0);
                    write_reg(pwve_pkg::REG_ENV_LENGTH, 9'd256);
                    write_reg(pwve_pkg::REG_ALLOC_MODE, 13'd1);
                end
                1: begin
                    write_reg(pwve_pkg::REG_ENV_LENGTH, 9'd1);
                    write_reg(pwve_pkg::REG_ALLOC_MODE, 13'd0);
                    write_reg(pwve_pkg::REG_LOOP_LENGTH, 13'd1);
                end
                2: begin
                    write_reg(pwve_pkg::REG_ENV_LENGTH, 9'd0);
                    write_reg(pwve_pkg::REG_ATTACK, 13'd4096);
                    write_reg(pwve_pkg::REG_LOOP_LENGTH, 13'd8191);
                end
                3: begin
                    write_reg(pwve_pkg::REG_ATTACK, 13'd2);
                    write_reg(pwve_pkg::REG_ENV_LENGTH, 9'd511);
                    write_reg(pwve_pkg::REG_WAVE_LENGTH, 13'd1);
                    write_reg(pwve_pkg::REG_LOOP_LENGTH, 13'd1);
                    write_reg(pwve_pkg::REG_ALLOC_MODE, 13'd1);
                end
                4: begin
                    write_reg(pwve_pkg::REG_WAVE_LENGTH, 13'd64);
                    write_reg(pwve_pkg::REG_LOOP_LENGTH, 13'd64);
                    write_reg(pwve_pkg::REG_ATTACK, 13'd8191);
                end
                default: begin
                    write_reg(pwve_pkg::REG_ATTACK, 13'd8);
                    write_reg(pwve_pkg::REG_ENV_LENGTH, 9'd20);
                    write_reg(pwve_pkg::REG_LOOP_LENGTH, 13'd32);
                end
            endcase
            for (int n = 0; n < 70; )
            begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < 70; b++, n++)
                begin
                    w = rand_word(8);
                    send_word(w, 1'b0, '0);
                end
                if ($urandom_range(0, 2) != 0)
                begin
                    gap();
                    repeat ($urandom_range(1, 25)) @(negedge clk);
                end
            end
            drain();
        end

        repeat (60) @(negedge clk);
        if (errors == 0 && expected_mix.size() == 0)
            $display("polyphonic_wavetable_voice_engine verification clean");
        else
            $display("polyphonic_wavetable_voice_engine verification failed");
        $finish;
    end
endmodule
